// ----- hw/rtl/wci_pkg.sv -----
// ----------------------------------------------------------------------------
// wci_pkg
// shared widths and the encoder symbol table for the whitened
// convolutional interleaver
// ----------------------------------------------------------------------------
package wci_pkg;

    localparam int BYTE_W  = 8;
    localparam int STATE_W = 3;
    localparam int SYM_W   = 2;
    localparam int DATA_W  = 2 * BYTE_W;
    localparam int WORD_W  = DATA_W * SYM_W;
    localparam int GRID_N  = 4;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [STATE_W-1:0] t_trellis;
    typedef logic [SYM_W-1:0]   t_sym;
    typedef logic [WORD_W-1:0]  t_word;

    // symbol for index {state, data bit}
    localparam t_sym SYM_TABLE [0:15] = '{
        2'd0, 2'd3,
        2'd1, 2'd2,
        2'd3, 2'd0,
        2'd2, 2'd1,
        2'd3, 2'd0,
        2'd2, 2'd1,
        2'd0, 2'd3,
        2'd1, 2'd2
    };

endpackage

// ----- hw/rtl/whitened_convolutional_interleaver.sv -----
// ----------------------------------------------------------------------------
// whitened_convolutional_interleaver
// whitens a byte pair, convolutionally encodes it and interleaves the
// 32 coded bits into one word
// ----------------------------------------------------------------------------
// One item per clock, sustained while the output side keeps m_axis_tready
// high: a pair is whitened and registered in the input stage on acceptance,
// then encoded and interleaved from that stage into the output register,
// where the word sits until it is taken. The trellis state register
// is the only carried state; it
// advances at acceptance from the low three whitened bits of the second
// byte and clears after an item flagged with tlast. Output tlast marks the
// word of that final pair.
module whitened_convolutional_interleaver (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // first_byte, second_byte, first_whiten, second_whiten
    input  logic [31:0]          s_axis_tdata,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // coded_word
    output wci_pkg::t_word       m_axis_tdata,
    output logic                 m_axis_tlast
);
    import wci_pkg::*;

    logic     w_s_acc;
    logic     w_adv1;
    t_byte    w_first;
    t_byte    w_second;
    t_word    w_coded;
    t_word    w_word;

    t_trellis r_trellis;
    t_trellis n_trellis;
    logic     r_v1;
    t_byte    r_first;
    t_byte    r_second;
    t_trellis r_st1;
    logic     r_last1;
    logic     r_v2;
    t_word    r_word;
    logic     r_end;

    assign w_first  = s_axis_tdata[7:0]   ^ s_axis_tdata[23:16];
    assign w_second = s_axis_tdata[15:8]  ^ s_axis_tdata[31:24];

    assign w_adv1        = !r_v2 || m_axis_tready;
    assign s_axis_tready = !r_v1 || w_adv1;
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    assign n_trellis = s_axis_tlast ? '0 : w_second[STATE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trellis <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            if (w_s_acc) begin
                r_trellis <= n_trellis;
            end
            if (s_axis_tready) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_adv1) begin
                r_v2 <= r_v1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_first  <= w_first;
            r_second <= w_second;
            r_st1    <= r_trellis;
            r_last1  <= s_axis_tlast;
        end
        if (w_adv1 && r_v1) begin
            r_word <= w_word;
            r_end  <= r_last1;
        end
    end

    wci_encoder u_encoder (
        .i_first  (r_first),
        .i_second (r_second),
        .i_state  (r_st1),
        .o_coded  (w_coded)
    );

    wci_interleaver u_interleaver (
        .i_coded (w_coded),
        .o_word  (w_word)
    );

    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = r_word;
    assign m_axis_tlast  = r_end;

    a_state_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && s_axis_tlast) |=> (r_trellis == '0))
        else $error("trellis state not cleared after last pair");

    a_state_next : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && !s_axis_tlast) |=>
            (r_trellis == $past(s_axis_tdata[10:8] ^ s_axis_tdata[26:24])))
        else $error("trellis state did not advance from second byte");

    a_stage_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_adv1) |=> (r_v1 && $stable(r_st1) && $stable(r_last1)))
        else $error("stalled item lost in input stage");

    a_accept_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> r_v1)
        else $error("accepted item not held in input stage");

endmodule

// ----- hw/rtl/wci_encoder.sv -----
// ----------------------------------------------------------------------------
// wci_encoder
// rate one-half, constraint-length-four encoder over one whitened byte
// pair, msb first, starting from the given trellis state
// ----------------------------------------------------------------------------
module wci_encoder (
    input  wci_pkg::t_byte    i_first,
    input  wci_pkg::t_byte    i_second,
    input  wci_pkg::t_trellis i_state,
    output wci_pkg::t_word    o_coded
);
    import wci_pkg::*;

    // state bits followed by the data bits, oldest at the top
    logic [STATE_W+DATA_W-1:0] w_window;

    assign w_window = {i_state, i_first, i_second};

    // each symbol sees the three bits before its own data bit
    for (genvar g = 0; g < DATA_W; g++) begin : g_sym
        assign o_coded[WORD_W-1-SYM_W*g -: SYM_W] =
            SYM_TABLE[w_window[STATE_W+DATA_W-1-g -: STATE_W+1]];
    end

endmodule

// ----- hw/rtl/wci_interleaver.sv -----
// ----------------------------------------------------------------------------
// wci_interleaver
// 4x4 interleave of two-bit symbols across one coded word
// ----------------------------------------------------------------------------
module wci_interleaver (
    input  wci_pkg::t_word i_coded,
    output wci_pkg::t_word o_word
);
    import wci_pkg::*;

    for (genvar k = 0; k < GRID_N * GRID_N; k++) begin : g_sym
        localparam int SRC = 4 * SYM_W * (k % GRID_N) + SYM_W * (k / GRID_N);
        assign o_word[WORD_W-1-SYM_W*k -: SYM_W] = i_coded[SRC +: SYM_W];
    end

endmodule

// ----- tb/whitened_convolutional_interleaver_tb.sv -----
// ----------------------------------------------------------------------------
// whitened_convolutional_interleaver_tb
// self-checking bench for the whitened convolutional interleaver
// ----------------------------------------------------------------------------
// Byte pairs with their whitening bytes are streamed in, first a few
// hand-picked pairs, then random packets of random length with some stray
// pairs in between. A behavioral encoder keeps its own trellis state,
// predicts the interleaved word for every accepted pair, and each output
// word is checked in order. Both sides pause at random; once the output
// side holds off long enough for the block to fill up and stall its input.
// ----------------------------------------------------------------------------
module whitened_convolutional_interleaver_tb;

    import wci_pkg::*;

    localparam int  CLK_HALF     = 10;
    localparam int  RESET_CYCLES = 6;
    localparam int  RANDOM_ITEMS = 1650;
    localparam int  MAX_GAP      = 16;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  HOLD_AFTER   = 500;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  WATCHDOG     = 8_000_000;

    // symbol for index {trellis state, data bit}
    localparam logic [1:0] CONV_SYMBOLS [16] = '{
        2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1,
        2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2
    };

    typedef struct {
        t_word word;
        logic  pkt_end;
    } t_coded_item;

    class coded_word_scoreboard;
        t_trellis    enc_state;
        t_coded_item pending_words[$];
        int unsigned errors;
        int unsigned pairs_seen;
        int unsigned words_checked;
        int unsigned packets_seen;

        function new();
            enc_state     = '0;
            errors        = 0;
            pairs_seen    = 0;
            words_checked = 0;
            packets_seen  = 0;
        endfunction

        // whiten, encode msb first, then interleave the 16 symbols
        function void note_pair(logic [31:0] data, logic last);
            logic [15:0] bits;
            t_word       enc;
            t_word       inter;
            int          s;
            t_coded_item exp_item;
            bits  = {data[7:0] ^ data[23:16], data[15:8] ^ data[31:24]};
            enc   = '0;
            inter = '0;
            for (int i = 15; i >= 0; i--) begin
                enc       = {enc[WORD_W-3:0], CONV_SYMBOLS[{enc_state, bits[i]}]};
                enc_state = {enc_state[1:0], bits[i]};
            end
            for (int k = 0; k < 16; k++) begin
                s     = 8 * (k % 4) + 2 * (k / 4);
                inter = {inter[WORD_W-3:0], enc[s +: 2]};
            end
            exp_item.word    = inter;
            exp_item.pkt_end = last;
            pending_words.push_back(exp_item);
            if (last) begin
                enc_state = '0;
                packets_seen++;
            end
            pairs_seen++;
        endfunction

        function void check_word(t_word word, logic last);
            t_coded_item exp_item;
            if (pending_words.size() == 0) begin
                $error("unexpected word %08h with no item pending", word);
                errors++;
                return;
            end
            exp_item = pending_words.pop_front();
            words_checked++;
            if (word !== exp_item.word) begin
                $error("coded_word mismatch: expected %08h, actual %08h",
                       exp_item.word, word);
                errors++;
            end
            if (last !== exp_item.pkt_end) begin
                $error("packet_end mismatch: expected %0b, actual %0b",
                       exp_item.pkt_end, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // first_byte, second_byte, first_whiten, second_whiten
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // coded_word
    t_word       m_axis_tdata;
    logic        m_axis_tlast;

    coded_word_scoreboard sb;
    bit send_quiet;
    bit recv_quiet;
    bit hold_done;

    whitened_convolutional_interleaver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_pair(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_word(m_axis_tdata, m_axis_tlast);
            end
        end
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic drive_pair(t_byte first_b, t_byte second_b, t_byte first_w,
                              t_byte second_w, logic last);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {second_w, first_w, second_b, first_b};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // random pair, sometimes whitened to all zeros or all ones
    task automatic drive_random_pair(logic last);
        t_byte fb;
        t_byte sb2;
        t_byte fw;
        t_byte sw;
        fb  = 8'($urandom);
        sb2 = 8'($urandom);
        fw  = 8'($urandom);
        sw  = 8'($urandom);
        case ($urandom_range(0, 7))
            0: begin
                fw = fb;
                sw = sb2;
            end
            1: begin
                fw = ~fb;
                sw = ~sb2;
            end
            default: ;
        endcase
        drive_pair(fb, sb2, fw, sw, last);
    endtask

    // output side: pause per item, with one long hold-off to back up the block
    initial begin
        int gap;
        hold_done = 1'b0;
        recv_quiet = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!hold_done && sb.words_checked >= HOLD_AFTER) begin
                gap = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                if ($urandom_range(0, 49) == 0) recv_quiet = ~recv_quiet;
                gap = draw_gap(recv_quiet);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        #(WATCHDOG * 2 * CLK_HALF);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int sent;
        int len;
        sb = new();
        send_quiet = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pairs: extremes, whitening cancel, packet ends back to back
        drive_pair(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        drive_pair(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0);
        drive_pair(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
        drive_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        drive_pair(8'hA5, 8'h5A, 8'h00, 8'h00, 1'b0);
        drive_pair(8'h5A, 8'hA5, 8'hFF, 8'hFF, 1'b1);
        drive_pair(8'h80, 8'h01, 8'h00, 8'h00, 1'b0);
        drive_pair(8'h01, 8'h80, 8'h00, 8'h00, 1'b1);
        drive_pair(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1);
        drive_pair(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        drive_pair(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
        drive_pair(8'h7F, 8'hFE, 8'h00, 8'h00, 1'b0);
        drive_pair(8'h12, 8'h34, 8'h56, 8'h78, 1'b1);
        drive_pair(8'hC3, 8'h3C, 8'h81, 8'h18, 1'b0);
        drive_pair(8'hFF, 8'h00, 8'h0F, 8'hF0, 1'b1);

        // random packets with stray pairs in between
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) send_quiet = ~send_quiet;
            if ($urandom_range(0, 9) == 0) begin
                drive_random_pair(1'($urandom_range(0, 1)));
                sent++;
            end else begin
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++) begin
                    drive_random_pair(i == len - 1);
                end
                sent += len;
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d pairs sent in %0d packets, %0d coded words checked",
                 sb.pairs_seen, sb.packets_seen, sb.words_checked);
        $display("random stalls on both sides, long output hold-off %s",
                 hold_done ? "applied" : "not reached");
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
